/* design/swrc_pkg.sv */
// Shared types, codes and constants for the sliding-window event rate counter.
package swrc_pkg;

  localparam int BUCKETS_DEF = 60;
  localparam int MODE_W      = 2;
  localparam int SEC_W       = 32;
  localparam int CNT_W       = 32;
  localparam int TOTAL_W     = 64;
  localparam int RECENT_W    = 38;

  localparam logic [MODE_W-1:0] MODE_LOG    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_IDX,
    S_RD,
    S_WR,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;      // transaction accepted
    logic mul;       // reciprocal multiply of the second
    logic idx;       // form bucket index
    logic ev_rd;     // read bucket for a log event
    logic ev_wr;     // write back updated bucket
    logic scan_rd;   // read next bucket of the window scan
    logic out_load;  // capture query result
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] in_mode;
    logic              scan_last;
    logic              out_free;
  } status_t;

endpackage

/* design/swrc_if.sv */
// Valid/ready channel interfaces for input items and query results.
interface swrc_in_if;
  logic                       valid;
  logic                       ready;
  logic [swrc_pkg::MODE_W-1:0] mode;
  logic [swrc_pkg::SEC_W-1:0]  current_second;

  modport source (output valid, output mode, output current_second, input ready);
  modport sink   (input valid, input mode, input current_second, output ready);
endinterface

interface swrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [swrc_pkg::TOTAL_W-1:0]  written_count;
  logic [swrc_pkg::TOTAL_W-1:0]  flushed_count;
  logic [swrc_pkg::RECENT_W-1:0] recent_lines;

  modport source (output valid, output written_count, output flushed_count,
                  output recent_lines, input ready);
  modport sink   (input valid, input written_count, input flushed_count,
                  input recent_lines, output ready);
endinterface

/* design/swrc_ctrl.sv */
// Controller state machine: sequences log updates and window scans.
module swrc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  swrc_pkg::status_t status,
  output swrc_pkg::cmd_t    cmd
);

  swrc_pkg::state_t state;
  swrc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swrc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      swrc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (status.in_mode)
            swrc_pkg::MODE_LOG:   state_next = swrc_pkg::S_MUL;
            swrc_pkg::MODE_QUERY: state_next = swrc_pkg::S_SCAN;
            default:              state_next = swrc_pkg::S_IDLE;
          endcase
        end
      end
      swrc_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = swrc_pkg::S_IDX;
      end
      swrc_pkg::S_IDX: begin
        cmd.idx    = 1'b1;
        state_next = swrc_pkg::S_RD;
      end
      swrc_pkg::S_RD: begin
        cmd.ev_rd  = 1'b1;
        state_next = swrc_pkg::S_WR;
      end
      swrc_pkg::S_WR: begin
        cmd.ev_wr  = 1'b1;
        state_next = swrc_pkg::S_IDLE;
      end
      swrc_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = swrc_pkg::S_DRAIN;
        end
      end
      swrc_pkg::S_DRAIN: begin
        state_next = swrc_pkg::S_DONE;
      end
      swrc_pkg::S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = swrc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = swrc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* design/swrc_dp.sv */
// Datapath: totals, bucket memory, index arithmetic, window accumulator, result register.
module swrc_dp #(
  parameter int BUCKETS = swrc_pkg::BUCKETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swrc_pkg::cmd_t                cmd,
  output swrc_pkg::status_t             status,
  input  logic [swrc_pkg::MODE_W-1:0]   in_mode,
  input  logic [swrc_pkg::SEC_W-1:0]    in_second,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swrc_pkg::TOTAL_W-1:0]  out_written,
  output logic [swrc_pkg::TOTAL_W-1:0]  out_flushed,
  output logic [swrc_pkg::RECENT_W-1:0] out_recent
);

  localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SH    = swrc_pkg::SEC_W + $clog2(BUCKETS);
  localparam logic [63:0] RECIP64 = ((64'd1 << SH) / BUCKETS) + 64'd1;
  localparam logic [32:0] RECIP   = RECIP64[32:0];
  localparam int ENT_W = swrc_pkg::SEC_W + swrc_pkg::CNT_W;

  logic [swrc_pkg::TOTAL_W-1:0]  written_total;
  logic [swrc_pkg::TOTAL_W-1:0]  flushed_total;
  logic [swrc_pkg::SEC_W-1:0]    now;
  logic [64:0]                   prod;
  logic [IDX_W-1:0]              idx;
  logic [IDX_W-1:0]              cnt;
  logic [ENT_W-1:0]              mem [BUCKETS];
  logic [BUCKETS-1:0]            vld;
  logic [ENT_W-1:0]              rd_q;
  logic                          rd_vld;
  logic                          acc_pend;
  logic [swrc_pkg::RECENT_W-1:0] sum;

  logic [swrc_pkg::SEC_W-1:0]    quot;
  logic [swrc_pkg::SEC_W-1:0]    rem;
  logic [IDX_W-1:0]              rd_addr;
  logic [swrc_pkg::SEC_W-1:0]    rd_tag;
  logic [swrc_pkg::CNT_W-1:0]    rd_cnt;
  logic [ENT_W-1:0]              wr_data;
  logic [swrc_pkg::SEC_W:0]      age;
  logic                          in_window;
  logic [swrc_pkg::RECENT_W:0]   sum_ext;

  assign quot    = swrc_pkg::SEC_W'(prod >> SH);
  assign rem     = now - (quot * swrc_pkg::SEC_W'(BUCKETS));
  assign rd_addr = cmd.scan_rd ? cnt : idx;
  assign rd_tag  = rd_vld ? rd_q[ENT_W-1:swrc_pkg::CNT_W] : '0;
  assign rd_cnt  = rd_vld ? rd_q[swrc_pkg::CNT_W-1:0] : '0;

  always_comb begin
    if (rd_tag == now) begin
      wr_data = {rd_tag, (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1};
    end else begin
      wr_data = {now, swrc_pkg::CNT_W'(1)};
    end
  end

  assign age       = {1'b0, now} - {1'b0, rd_tag};
  assign in_window = !age[swrc_pkg::SEC_W] &&
                     (age[swrc_pkg::SEC_W-1:0] < swrc_pkg::SEC_W'(BUCKETS));
  assign sum_ext   = {1'b0, sum} + (in_window ? (swrc_pkg::RECENT_W+1)'(rd_cnt) : '0);

  assign status.in_mode   = in_mode;
  assign status.scan_last = (cnt == IDX_W'(BUCKETS - 1));
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      written_total <= '0;
      flushed_total <= '0;
    end else if (cmd.load) begin
      if (in_mode == swrc_pkg::MODE_LOG) begin
        written_total <= written_total + 1'b1;
      end
      if (in_mode == swrc_pkg::MODE_FLUSH) begin
        flushed_total <= flushed_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now <= in_second;
    end
    if (cmd.mul) begin
      prod <= {33'b0, now} * {32'b0, RECIP};
    end
    if (cmd.idx) begin
      idx <= IDX_W'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ev_wr) begin
      mem[idx] <= wr_data;
    end
    if (cmd.ev_rd || cmd.scan_rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.ev_wr) begin
        vld[idx] <= 1'b1;
      end
      if (cmd.ev_rd || cmd.scan_rd) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      acc_pend <= 1'b0;
      sum      <= '0;
    end else begin
      acc_pend <= cmd.scan_rd;
      if (cmd.load) begin
        cnt <= '0;
        sum <= '0;
      end else begin
        if (cmd.scan_rd) begin
          cnt <= cnt + 1'b1;
        end
        if (acc_pend) begin
          sum <= sum_ext[swrc_pkg::RECENT_W] ? '1 : sum_ext[swrc_pkg::RECENT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_written <= written_total;
      out_flushed <= flushed_total;
      out_recent  <= sum;
    end
  end

endmodule

/* design/sliding_window_event_rate_counter_unit.sv */
// Log event: accepted, then steps through multiply, index, bucket read and write before ready again.
// Flush event or unused mode: ready again the next cycle.
// Query: after acceptance, scan, drain and load, then result valid; one bucket per cycle while scanning.
// A waiting result is held in an output register; a later query scans meanwhile and then
// stalls until that result is taken.
// Synchronous reset zeroes both totals and clears all bucket valid bits.
// Top level of the sliding-window event rate counter.
module sliding_window_event_rate_counter_unit #(
  parameter int BUCKETS = swrc_pkg::BUCKETS_DEF
) (
  input logic        clk,
  input logic        rst,
  swrc_in_if.sink    item,
  swrc_out_if.source result
);

  swrc_pkg::cmd_t    cmd;
  swrc_pkg::status_t status;

  swrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  swrc_dp #(
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_mode     (item.mode),
    .in_second   (item.current_second),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_written (result.written_count),
    .out_flushed (result.flushed_count),
    .out_recent  (result.recent_lines)
  );

endmodule

/* design/swrc_checker.sv */
// Port-level checker for the rate counter, bound to the top level.
module swrc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [swrc_pkg::MODE_W-1:0]   in_mode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [swrc_pkg::RECENT_W-1:0] out_recent
);

  // A busy operation blocks the next transaction.
  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
    (in_mode == swrc_pkg::MODE_LOG || in_mode == swrc_pkg::MODE_QUERY) |=> !in_ready)
    else $error("ready still high after log or query transaction");

  a_quick_ops: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
    (in_mode == swrc_pkg::MODE_FLUSH || in_mode == swrc_pkg::MODE_UNUSED) |=> in_ready)
    else $error("ready dropped after flush or ignored transaction");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_recent))
    else $error("stalled result changed");

endmodule

bind sliding_window_event_rate_counter_unit swrc_checker u_swrc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (item.valid),
  .in_ready   (item.ready),
  .in_mode    (item.mode),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_recent (result.recent_lines)
);
